// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of the execute unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/rseu_pkg.sv =====
// Shared constants, beat types, decode tables and helpers of the execute unit.
package rseu_pkg;

  localparam int DATA_WORDS = 256;
  localparam int PROG_DEPTH = 1024;
  localparam int XLEN       = 32;
  localparam int RF_DEPTH   = 32;
  localparam int RF_AW      = 5;
  localparam int DM_AW      = $clog2(DATA_WORDS);
  localparam int PC_W       = $clog2(PROG_DEPTH);
  localparam int CLR_WORDS  = (DATA_WORDS > RF_DEPTH) ? DATA_WORDS : RF_DEPTH;
  localparam int CLR_AW     = $clog2(CLR_WORDS);
  localparam logic [XLEN-1:0] DM_BYTES = XLEN'(DATA_WORDS * 4);

  // Result queue depth (power of two).
  localparam int OQ_DEPTH = 2;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  // Instruction categories, bits 31:29.
  localparam logic [2:0] CAT_BRANCH = 3'd1;
  localparam logic [2:0] CAT_IMM    = 3'd2;
  localparam logic [2:0] CAT_REG    = 3'd3;
  localparam logic [2:0] CAT_MEM    = 3'd4;
  localparam logic [2:0] CAT_HALT   = 3'd5;

  // Opcodes.
  localparam logic [4:0] OP_CBZ  = 5'd16;
  localparam logic [4:0] OP_CBNZ = 5'd17;
  localparam logic [6:0] OP_ORRI = 7'd64;
  localparam logic [6:0] OP_EORI = 7'd65;
  localparam logic [6:0] OP_ADDI = 7'd66;
  localparam logic [6:0] OP_SUBI = 7'd67;
  localparam logic [6:0] OP_ANDI = 7'd68;
  localparam logic [7:0] OP_EOR  = 8'd160;
  localparam logic [7:0] OP_ADD  = 8'd162;
  localparam logic [7:0] OP_SUB  = 8'd163;
  localparam logic [7:0] OP_AND  = 8'd164;
  localparam logic [7:0] OP_ORR  = 8'd165;
  localparam logic [7:0] OP_LSR  = 8'd166;
  localparam logic [7:0] OP_LSL  = 8'd167;
  localparam logic [7:0] OP_LDUR = 8'd170;
  localparam logic [7:0] OP_STUR = 8'd171;

  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] item_word;
    logic [9:0]  preload_address;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         next_index;
    logic               halted;
    logic               illegal;
    logic               mem_fault;
    logic               wb_valid;
    logic [4:0]         wb_reg;
    logic signed [31:0] wb_value;
  } out_item_t;

  // Register file read ports for one instruction.
  typedef struct packed {
    logic [RF_AW-1:0] ra;
    logic [RF_AW-1:0] rb;
  } rf_rd_t;

  // Execute stage outcome handed to the writeback stage.
  typedef struct packed {
    logic             halted;
    logic             illegal;
    logic             mem_fault;
    logic             wb_valid;
    logic [4:0]       wb_reg;
    logic [XLEN-1:0]  wb_value;
    logic             is_load;
    logic             dm_we;
    logic [DM_AW-1:0] dm_addr;
    logic [XLEN-1:0]  dm_wdata;
    logic             keep_pc;
    logic             take;
    pc_t              inc;
    pc_t              br_a;
    pc_t              br_b;
  } exec_res_t;

  // Residue tables for the branch offset: low and middle 7-bit slices, signed top slice.
  typedef pc_t res7_tbl_t [128];
  typedef pc_t res5_tbl_t [32];

  function automatic res7_tbl_t build_res7(int sh);
    res7_tbl_t t;
    longint    m;
    for (int i = 0; i < 128; i++) begin
      m    = (longint'(i) <<< sh) % PROG_DEPTH;
      t[i] = PC_W'(m);
    end
    return t;
  endfunction

  function automatic res5_tbl_t build_res_hi();
    res5_tbl_t t;
    longint    m;
    longint    h;
    for (int i = 0; i < 32; i++) begin
      h = (i >= 16) ? longint'(i - 32) : longint'(i);
      m = (h * 16384) % PROG_DEPTH;
      if (m < 0) begin
        m = m + PROG_DEPTH;
      end
      t[i] = PC_W'(m);
    end
    return t;
  endfunction

  localparam res7_tbl_t OFF_LO_RES  = build_res7(0);
  localparam res7_tbl_t OFF_MID_RES = build_res7(7);
  localparam res5_tbl_t OFF_HI_RES  = build_res_hi();

  // Sum of two residues, folded back below the program depth.
  function automatic pc_t add_mod(pc_t x, pc_t y);
    logic [PC_W:0] s;
    logic [PC_W:0] d;
    s = {1'b0, x} + {1'b0, y};
    d = s - (PC_W+1)'(PROG_DEPTH);
    return (s >= (PC_W+1)'(PROG_DEPTH)) ? d[PC_W-1:0] : s[PC_W-1:0];
  endfunction

  function automatic logic addr_ok(logic [XLEN-1:0] a);
    return (a[1:0] == 2'b00) && (a < DM_BYTES);
  endfunction

  function automatic logic [DM_AW-1:0] dm_index(logic [XLEN-1:0] a);
    return a[DM_AW+1:2];
  endfunction

  // Register file read addresses by instruction category.
  function automatic rf_rd_t rf_ports(in_item_t it);
    rf_rd_t p;
    p = '0;
    unique case (it.item_word[31:29])
      CAT_BRANCH: p.ra = it.item_word[23:19];
      CAT_IMM:    p.ra = it.item_word[16:12];
      CAT_REG: begin
        p.ra = it.item_word[15:11];
        p.rb = it.item_word[10:6];
      end
      CAT_MEM: begin
        p.ra = it.item_word[15:11];
        p.rb = it.item_word[20:16];
      end
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

// ===== sv/risc_subset_execute_unit_top.sv =====
// Top level of the execute unit: register file, data memory and the two-stage pipeline.
//
// Input channel in_valid/in_ready/in_data carries one beat per instruction word
// (mode 0) or per data word to preload (mode 1). Result channel
// out_valid/out_ready/out_data returns exactly one beat per input beat, in order.
// An instruction reads the register file when it is accepted, executes in the
// next cycle (ALU, branch, data memory address) and writes back in the cycle after
// that, where loads take the data memory read and the result enters the result queue.
// No new beat is accepted while an instruction is in the execute stage: the register
// file copies and the data memory have one synchronous read port each, and an
// instruction's register read overlaps the writeback of the one before it, which
// is forwarded. A two-beat result queue sits at the output; when the receiver
// stalls, the queue fills and in_ready drops, and no work is lost.
// After reset a clearing pass zeroes the data memory and the register file, one entry
// a cycle; in_ready stays low until it ends. The instruction index resets to zero.
module risc_subset_execute_unit_top import rseu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic             clr_busy_r;
  logic [CLR_AW-1:0] clr_cnt_r;
  logic             s1_v_r;
  in_item_t         s1_item_r;
  logic             s2_v_r;
  exec_res_t        s2_res_r;
  pc_t              pc_r;
  pc_t              pc_nxt;
  logic             lw_v_r;
  logic [RF_AW-1:0] lw_addr_r;
  logic [XLEN-1:0]  lw_data_r;

  logic             accept;
  logic             q_room;
  rf_rd_t           rd_in;
  rf_rd_t           rd_s1;
  logic [XLEN-1:0]  rf_a_rdata;
  logic [XLEN-1:0]  rf_b_rdata;
  logic [XLEN-1:0]  opa;
  logic [XLEN-1:0]  opb;
  exec_res_t        ex_res;
  logic             rf_we;
  logic [RF_AW-1:0] rf_waddr;
  logic [XLEN-1:0]  rf_wdata;
  logic             dm_we;
  logic [DM_AW-1:0] dm_waddr;
  logic [XLEN-1:0]  dm_wdata;
  logic [XLEN-1:0]  dm_rdata;
  logic             wb_hit;
  logic [XLEN-1:0]  wb_data;
  logic [15:0]      idx_wide;
  out_item_t        push_item;

  // Accept when the clearing pass is done, the execute stage is idle and the queue has room.
  assign in_ready = !clr_busy_r && !s1_v_r && q_room;
  assign accept   = in_valid && in_ready;

  assign rd_in = rf_ports(in_data);
  assign rd_s1 = rf_ports(s1_item_r);

  // Forward a writeback that landed on the same edge as this read.
  assign opa = (lw_v_r && lw_addr_r == rd_s1.ra) ? lw_data_r : rf_a_rdata;
  assign opb = (lw_v_r && lw_addr_r == rd_s1.rb) ? lw_data_r : rf_b_rdata;

  rseu_exec u_exec (
    .item (s1_item_r),
    .opa  (opa),
    .opb  (opb),
    .pc   (pc_r),
    .res  (ex_res)
  );

  // Writeback stage values.
  assign wb_hit  = s2_v_r && s2_res_r.wb_valid;
  assign wb_data = s2_res_r.is_load ? dm_rdata : s2_res_r.wb_value;

  always_comb begin
    if (s2_res_r.keep_pc) begin
      pc_nxt = pc_r;
    end else if (s2_res_r.take) begin
      pc_nxt = add_mod(s2_res_r.br_a, s2_res_r.br_b);
    end else begin
      pc_nxt = s2_res_r.inc;
    end
  end

  assign idx_wide = 16'(pc_nxt);

  always_comb begin
    push_item            = '0;
    push_item.next_index = idx_wide[9:0];
    push_item.halted     = s2_res_r.halted;
    push_item.illegal    = s2_res_r.illegal;
    push_item.mem_fault  = s2_res_r.mem_fault;
    push_item.wb_valid   = s2_res_r.wb_valid;
    push_item.wb_reg     = s2_res_r.wb_reg;
    push_item.wb_value   = s2_res_r.wb_valid ? wb_data : '0;
  end

  // Memory write ports: clearing pass first, then writeback.
  always_comb begin
    if (clr_busy_r) begin
      rf_we    = ({1'b0, clr_cnt_r} < (CLR_AW+1)'(RF_DEPTH));
      rf_waddr = clr_cnt_r[RF_AW-1:0];
      rf_wdata = '0;
      dm_we    = ({1'b0, clr_cnt_r} < (CLR_AW+1)'(DATA_WORDS));
      dm_waddr = clr_cnt_r[DM_AW-1:0];
      dm_wdata = '0;
    end else begin
      rf_we    = wb_hit;
      rf_waddr = s2_res_r.wb_reg;
      rf_wdata = wb_data;
      dm_we    = s2_v_r && s2_res_r.dm_we;
      dm_waddr = s2_res_r.dm_addr;
      dm_wdata = s2_res_r.dm_wdata;
    end
  end

  rseu_ram #(.WIDTH(XLEN), .DEPTH(RF_DEPTH)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rd_in.ra),
    .rdata (rf_a_rdata)
  );

  rseu_ram #(.WIDTH(XLEN), .DEPTH(RF_DEPTH)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rd_in.rb),
    .rdata (rf_b_rdata)
  );

  rseu_ram #(.WIDTH(XLEN), .DEPTH(DATA_WORDS)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .raddr (ex_res.dm_addr),
    .rdata (dm_rdata)
  );

  rseu_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s2_v_r),
    .push_data (push_item),
    .room      (q_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_data;
    end
    if (s1_v_r) begin
      s2_res_r <= ex_res;
    end
    lw_addr_r <= rf_waddr;
    lw_data_r <= rf_wdata;
  end

  // Control: clearing pass, stage valids, index and forward flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      pc_r       <= '0;
      lw_v_r     <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        if (clr_cnt_r == CLR_AW'(CLR_WORDS - 1)) begin
          clr_busy_r <= 1'b0;
        end else begin
          clr_cnt_r <= clr_cnt_r + CLR_AW'(1);
        end
      end
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      lw_v_r <= wb_hit && !clr_busy_r;
      if (s2_v_r) begin
        pc_r <= pc_nxt;
      end
    end
  end

endmodule

// ===== sv/rseu_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module rseu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, old data on a same-address write.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/rseu_outq.sv =====
// Result queue that decouples the writeback stage from the output channel.
module rseu_outq import rseu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_data,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  out_item_t        q_mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_r;
  logic [OQ_AW-1:0] rd_ptr_r;
  logic [OQ_CW-1:0] cnt_r;
  logic [OQ_CW-1:0] cnt_nxt;
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = q_mem[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  // Room for one more item beyond the beat already on its way in.
  assign room = ({1'b0, cnt_r} + (OQ_CW+1)'(push)) < (OQ_CW+1)'(OQ_DEPTH);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + OQ_CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - OQ_CW'(1);
    end
  end

  // Store pushed beats.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + OQ_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + OQ_AW'(1);
      end
    end
  end

endmodule

// ===== sv/rseu_exec.sv =====
// Execute stage: decode, ALU, branch residues and data memory address check.
module rseu_exec import rseu_pkg::*; (
  input  in_item_t        item,
  input  logic [XLEN-1:0] opa,
  input  logic [XLEN-1:0] opb,
  input  pc_t             pc,
  output exec_res_t       res
);

  logic [31:0]     w;
  logic [2:0]      cat;
  logic [4:0]      br_op;
  logic [6:0]      imm_op;
  logic [7:0]      rr_op;
  logic [XLEN-1:0] imm;
  logic [XLEN-1:0] base;
  logic [XLEN-1:0] mem_addr;
  logic [XLEN-1:0] pl_addr;

  assign w        = item.item_word;
  assign cat      = w[31:29];
  assign br_op    = w[28:24];
  assign imm_op   = w[28:22];
  assign rr_op    = w[28:21];
  assign imm      = {{20{w[11]}}, w[11:0]};
  assign base     = (w[15:11] == 5'd31) ? '0 : opa;
  assign mem_addr = base + {{21{w[10]}}, w[10:0]};
  assign pl_addr  = {22'b0, item.preload_address};

  always_comb begin
    res      = '0;
    res.inc  = (pc == PC_W'(PROG_DEPTH - 1)) ? '0 : pc + PC_W'(1);
    // Branch target residues, finished in the writeback stage.
    res.br_a = add_mod(OFF_LO_RES[w[6:0]], OFF_MID_RES[w[13:7]]);
    res.br_b = add_mod(pc, OFF_HI_RES[w[18:14]]);

    if (item.mode) begin
      // Preload a data word; the index holds.
      res.keep_pc = 1'b1;
      if (addr_ok(pl_addr)) begin
        res.dm_we    = 1'b1;
        res.dm_addr  = dm_index(pl_addr);
        res.dm_wdata = w;
      end else begin
        res.mem_fault = 1'b1;
      end
    end else begin
      unique case (cat)
        CAT_BRANCH: begin
          if (br_op == OP_CBZ) begin
            res.take = (opa == '0);
          end else if (br_op == OP_CBNZ) begin
            res.take = (opa != '0);
          end else begin
            res.illegal = 1'b1;
          end
        end
        CAT_IMM: begin
          res.wb_valid = 1'b1;
          res.wb_reg   = w[21:17];
          unique case (imm_op)
            OP_ORRI: res.wb_value = opa | imm;
            OP_EORI: res.wb_value = opa ^ imm;
            OP_ADDI: res.wb_value = opa + imm;
            OP_SUBI: res.wb_value = opa - imm;
            OP_ANDI: res.wb_value = opa & imm;
            default: begin
              res.wb_valid = 1'b0;
              res.wb_reg   = '0;
              res.illegal  = 1'b1;
            end
          endcase
        end
        CAT_REG: begin
          res.wb_valid = 1'b1;
          res.wb_reg   = w[20:16];
          unique case (rr_op)
            OP_EOR:  res.wb_value = opa ^ opb;
            OP_ADD:  res.wb_value = opa + opb;
            OP_SUB:  res.wb_value = opa - opb;
            OP_AND:  res.wb_value = opa & opb;
            OP_ORR:  res.wb_value = opa | opb;
            OP_LSR:  res.wb_value = (opb >= XLEN'(32)) ? '0 : (opa >> opb[4:0]);
            OP_LSL:  res.wb_value = (opb >= XLEN'(32)) ? '0 : (opa << opb[4:0]);
            default: begin
              res.wb_valid = 1'b0;
              res.wb_reg   = '0;
              res.illegal  = 1'b1;
            end
          endcase
        end
        CAT_MEM: begin
          if (rr_op == OP_LDUR || rr_op == OP_STUR) begin
            if (!addr_ok(mem_addr)) begin
              res.mem_fault = 1'b1;
            end else if (rr_op == OP_LDUR) begin
              res.wb_valid = 1'b1;
              res.wb_reg   = w[20:16];
              res.is_load  = 1'b1;
              res.dm_addr  = dm_index(mem_addr);
            end else begin
              res.dm_we    = 1'b1;
              res.dm_addr  = dm_index(mem_addr);
              res.dm_wdata = opb;
            end
          end else begin
            res.illegal = 1'b1;
          end
        end
        CAT_HALT: res.halted = 1'b1;
        default:  res.illegal = 1'b1;
      endcase
    end
  end

endmodule

// ===== sv/rseu_checker.sv =====
// Port-level checker for the execute unit, bound to the top level.
`include "assert_macros.svh"

module rseu_checker import rseu_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // Reset leaves no result and blocks input while memories clear.
  `ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid && !in_ready, "activity right after reset")

  // Beats are never accepted back to back.
  `ASSERT_CLK(a_accept_spacing, in_valid && in_ready |=> !in_ready, "back-to-back accept")

  // Each accepted beat is followed by a valid result beat on the output.
  `ASSERT_CLK(a_result_latency, in_valid && in_ready |-> ##3 out_valid, "result missing")

  // A stalled result beat holds.
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data),
    "result beat changed under stall")

endmodule

bind risc_subset_execute_unit_top rseu_checker u_rseu_checker (.*);

// ===== sim/risc_subset_execute_unit_top_test.sv =====
// Self-checking testbench for the execute unit: directed and random beats, scoreboard check.
`timescale 1ns / 1ps

import rseu_pkg::*;

// Tracks architectural state, predicts each result beat and checks what comes back.
class execute_scoreboard;
  logic [31:0] regs [RF_DEPTH];
  logic [31:0] dmem [DATA_WORDS];
  pc_t         pc;
  out_item_t   pending_retires [$];
  int unsigned issued;
  int unsigned preloads;
  int unsigned checked;
  int unsigned mismatches;
  int unsigned taken;
  int unsigned faults;
  int unsigned illegals;
  int unsigned halts;

  function new();
    foreach (regs[i]) regs[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    pc = '0;
    issued = 0;
    preloads = 0;
    checked = 0;
    mismatches = 0;
    taken = 0;
    faults = 0;
    illegals = 0;
    halts = 0;
  endfunction

  // Word aligned and inside the data memory.
  function logic addr_fits(logic [31:0] a);
    return (a[1:0] == 2'b00) && (a < 32'(DATA_WORDS * 4));
  endfunction

  // Execute one beat against the tracked state and return its result.
  function out_item_t run_instruction(in_item_t it);
    out_item_t   r;
    logic [31:0] w;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] imm;
    logic [31:0] addr;
    r = '0;
    w = it.item_word;
    r.next_index = pc + 1'b1;
    if (it.mode) begin
      // Preload leaves the index where it is.
      r.next_index = pc;
      if (addr_fits({22'b0, it.preload_address})) begin
        dmem[it.preload_address[DM_AW+1:2]] = w;
      end else begin
        r.mem_fault = 1'b1;
      end
    end else begin
      case (w[31:29])
        CAT_BRANCH: begin
          a = regs[w[23:19]];
          if (w[28:24] == OP_CBZ || w[28:24] == OP_CBNZ) begin
            // Target wraps modulo the program depth, so only the low offset bits matter.
            if ((w[28:24] == OP_CBZ) == (a == 32'd0)) begin
              r.next_index = pc + w[PC_W-1:0];
              taken++;
            end
          end else begin
            r.illegal = 1'b1;
          end
        end
        CAT_IMM: begin
          a = regs[w[16:12]];
          imm = {{20{w[11]}}, w[11:0]};
          r.wb_valid = 1'b1;
          case (w[28:22])
            OP_ORRI: r.wb_value = a | imm;
            OP_EORI: r.wb_value = a ^ imm;
            OP_ADDI: r.wb_value = a + imm;
            OP_SUBI: r.wb_value = a - imm;
            OP_ANDI: r.wb_value = a & imm;
            default: begin
              r.wb_valid = 1'b0;
              r.illegal = 1'b1;
            end
          endcase
          if (r.wb_valid) begin
            r.wb_reg = w[21:17];
            regs[w[21:17]] = r.wb_value;
          end
        end
        CAT_REG: begin
          a = regs[w[15:11]];
          b = regs[w[10:6]];
          r.wb_valid = 1'b1;
          case (w[28:21])
            OP_EOR: r.wb_value = a ^ b;
            OP_ADD: r.wb_value = a + b;
            OP_SUB: r.wb_value = a - b;
            OP_AND: r.wb_value = a & b;
            OP_ORR: r.wb_value = a | b;
            OP_LSR: r.wb_value = (b >= 32'd32) ? 32'd0 : (a >> b[4:0]);
            OP_LSL: r.wb_value = (b >= 32'd32) ? 32'd0 : (a << b[4:0]);
            default: begin
              r.wb_valid = 1'b0;
              r.illegal = 1'b1;
            end
          endcase
          if (r.wb_valid) begin
            r.wb_reg = w[20:16];
            regs[w[20:16]] = r.wb_value;
          end
        end
        CAT_MEM: begin
          // Base register 31 reads as zero here only.
          a = (w[15:11] == 5'd31) ? 32'd0 : regs[w[15:11]];
          addr = a + {{21{w[10]}}, w[10:0]};
          if (w[28:21] == OP_LDUR || w[28:21] == OP_STUR) begin
            if (!addr_fits(addr)) begin
              r.mem_fault = 1'b1;
            end else if (w[28:21] == OP_LDUR) begin
              r.wb_valid = 1'b1;
              r.wb_reg = w[20:16];
              r.wb_value = dmem[addr[DM_AW+1:2]];
              regs[w[20:16]] = r.wb_value;
            end else begin
              dmem[addr[DM_AW+1:2]] = regs[w[20:16]];
            end
          end else begin
            r.illegal = 1'b1;
          end
        end
        CAT_HALT: r.halted = 1'b1;
        default: r.illegal = 1'b1;
      endcase
    end
    pc = r.next_index;
    return r;
  endfunction

  // Note an accepted input beat and queue its expected result.
  function void note_issue(in_item_t it);
    out_item_t r;
    r = run_instruction(it);
    issued++;
    if (it.mode) preloads++;
    if (r.mem_fault) faults++;
    if (r.illegal) illegals++;
    if (r.halted) halts++;
    pending_retires = {pending_retires, r};
  endfunction

  function int pending();
    return pending_retires.size();
  endfunction

  task report_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  task check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s got %h want %h", checked, name, got, want));
    end
  endtask

  // Compare one result beat with the oldest expectation.
  task check_retire(out_item_t got);
    out_item_t want;
    if (pending_retires.size() == 0) begin
      report_mismatch($sformatf("result beat %h with nothing expected", got));
      return;
    end
    want = pending_retires.pop_front();
    checked++;
    check_field("next_index", 32'(got.next_index), 32'(want.next_index));
    check_field("halted", 32'(got.halted), 32'(want.halted));
    check_field("illegal", 32'(got.illegal), 32'(want.illegal));
    check_field("mem_fault", 32'(got.mem_fault), 32'(want.mem_fault));
    check_field("wb_valid", 32'(got.wb_valid), 32'(want.wb_valid));
    check_field("wb_reg", 32'(got.wb_reg), 32'(want.wb_reg));
    check_field("wb_value", got.wb_value, want.wb_value);
  endtask
endclass

module risc_subset_execute_unit_top_test;

  localparam int RANDOM_ITEMS = 1700;

  localparam logic [6:0] IMM_OPS [5] = '{OP_ORRI, OP_EORI, OP_ADDI, OP_SUBI, OP_ANDI};
  localparam logic [7:0] REG_OPS [7] = '{OP_EOR, OP_ADD, OP_SUB, OP_AND, OP_ORR, OP_LSR, OP_LSL};

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      calm;

  execute_scoreboard sb;
  in_item_t          directed [$];

  risc_subset_execute_unit_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Instruction encoders.
  function automatic logic [31:0] enc_branch(logic [4:0] op, logic [4:0] r, logic [18:0] off);
    return {CAT_BRANCH, op, r, off};
  endfunction

  function automatic logic [31:0] enc_imm(logic [6:0] op, logic [4:0] d, logic [4:0] s,
                                          logic [11:0] imm);
    return {CAT_IMM, op, d, s, imm};
  endfunction

  function automatic logic [31:0] enc_reg(logic [7:0] op, logic [4:0] d, logic [4:0] a,
                                          logic [4:0] b);
    return {CAT_REG, op, d, a, b, 6'b0};
  endfunction

  function automatic logic [31:0] enc_mem(logic [7:0] op, logic [4:0] rt, logic [4:0] rb,
                                          logic [10:0] off);
    return {CAT_MEM, op, rt, rb, off};
  endfunction

  function automatic in_item_t exec_beat(logic [31:0] w);
    return {1'b0, w, 10'($urandom)};
  endfunction

  function automatic in_item_t preload_beat(logic [9:0] addr, logic [31:0] w);
    return {1'b1, w, addr};
  endfunction

  // Append one beat to the directed list.
  task add_directed(in_item_t it);
    directed = {directed, it};
  endtask

  // Favor a few low registers so results feed later instructions.
  function automatic logic [4:0] rand_reg();
    return ($urandom_range(0, 99) < 70) ? 5'($urandom_range(0, 7)) : 5'($urandom);
  endfunction

  // Mostly well-formed instructions with random content, some preloads and noise.
  function automatic in_item_t make_random_item();
    in_item_t    it;
    int unsigned pick;
    logic [18:0] boff;
    logic [11:0] imm;
    logic [10:0] moff;
    logic [4:0]  base;
    it.mode = 1'b0;
    it.item_word = $urandom;
    it.preload_address = 10'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      it.mode = 1'b1;
      if ($urandom_range(0, 9) != 0) it.preload_address[1:0] = 2'b00;
    end else if (pick < 20) begin
      boff = ($urandom_range(0, 1) != 0) ? 19'($urandom_range(0, 16)) - 19'd8 : 19'($urandom);
      it.item_word = enc_branch(($urandom_range(0, 9) != 0) ?
                                (($urandom_range(0, 1) != 0) ? OP_CBZ : OP_CBNZ) :
                                5'($urandom), rand_reg(), boff);
    end else if (pick < 45) begin
      imm = ($urandom_range(0, 2) == 0) ? 12'($urandom_range(0, 31)) : 12'($urandom);
      it.item_word = enc_imm(($urandom_range(0, 9) != 0) ? IMM_OPS[$urandom_range(0, 4)] :
                             7'($urandom), rand_reg(), rand_reg(), imm);
    end else if (pick < 70) begin
      it.item_word = enc_reg(($urandom_range(0, 9) != 0) ? REG_OPS[$urandom_range(0, 6)] :
                             8'($urandom), rand_reg(), rand_reg(), rand_reg())
                     | 32'($urandom_range(0, 63));
    end else if (pick < 90) begin
      case ($urandom_range(0, 4))
        0, 1, 2: begin
          base = 5'd31;
          moff = {1'b0, 8'($urandom), 2'b00};
        end
        3: begin
          base = rand_reg();
          moff = {5'b0, 4'($urandom), 2'b00};
        end
        default: begin
          base = 5'($urandom);
          moff = 11'($urandom);
        end
      endcase
      it.item_word = enc_mem(($urandom_range(0, 9) != 0) ?
                             (($urandom_range(0, 1) != 0) ? OP_LDUR : OP_STUR) :
                             8'($urandom), rand_reg(), base, moff);
    end else if (pick < 93) begin
      it.item_word = {CAT_HALT, 29'($urandom)};
    end
    return it;
  endfunction

  // Present one beat, idling first at random, and hold it until accepted.
  task send_item(in_item_t it);
    if (!calm) begin
      while ($urandom_range(0, 99) < 17) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_issue(it);
  endtask

  // Drop valid and hold off until every expected result has come back.
  task wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Check result beats and stall the result channel at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_retire(out_data);
    out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 17);
  end

  initial begin
    sb = new();
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_ready <= 1'b0;
    calm      <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: preload edges, every opcode, immediate and shift extremes, faults, branches.
    add_directed(preload_beat(10'd0, 32'hFFFF_FFFF));
    add_directed(preload_beat(10'd1020, 32'h8000_0001));
    add_directed(preload_beat(10'h3FF, 32'h1234_5678));
    add_directed(exec_beat(enc_imm(OP_ADDI, 5'd1, 5'd31, 12'h7FF)));
    add_directed(exec_beat(enc_imm(OP_SUBI, 5'd2, 5'd1, 12'h800)));
    add_directed(exec_beat(enc_imm(OP_ORRI, 5'd3, 5'd2, 12'h800)));
    add_directed(exec_beat(enc_imm(OP_EORI, 5'd4, 5'd3, 12'hFFF)));
    add_directed(exec_beat(enc_imm(OP_ANDI, 5'd5, 5'd3, 12'h0F0)));
    add_directed(exec_beat(enc_imm(OP_ADDI, 5'd12, 5'd31, 12'd31)));
    add_directed(exec_beat(enc_reg(OP_ADD, 5'd6, 5'd1, 5'd2)));
    add_directed(exec_beat(enc_reg(OP_SUB, 5'd7, 5'd5, 5'd6)));
    add_directed(exec_beat(enc_reg(OP_EOR, 5'd8, 5'd3, 5'd7)));
    add_directed(exec_beat(enc_reg(OP_AND, 5'd9, 5'd3, 5'd4)));
    add_directed(exec_beat(enc_reg(OP_ORR, 5'd10, 5'd1, 5'd7)));
    add_directed(exec_beat(enc_reg(OP_LSL, 5'd11, 5'd1, 5'd12)));
    add_directed(exec_beat(enc_reg(OP_LSR, 5'd13, 5'd3, 5'd12)));
    add_directed(exec_beat(enc_reg(OP_LSL, 5'd15, 5'd1, 5'd2)));
    add_directed(exec_beat(enc_mem(OP_LDUR, 5'd17, 5'd31, 11'd1020)));
    add_directed(exec_beat(enc_mem(OP_STUR, 5'd7, 5'd31, 11'd8)));
    add_directed(exec_beat(enc_mem(OP_LDUR, 5'd19, 5'd31, 11'd8)));
    add_directed(exec_beat(enc_mem(OP_LDUR, 5'd20, 5'd31, 11'd2)));
    add_directed(exec_beat(enc_mem(OP_LDUR, 5'd20, 5'd31, 11'h7FC)));
    add_directed(exec_beat(enc_mem(OP_STUR, 5'd20, 5'd1, 11'd1)));
    add_directed(exec_beat(enc_mem(8'd0, 5'd1, 5'd2, 11'd0)));
    add_directed(exec_beat(enc_branch(OP_CBZ, 5'd31, 19'h7FFFD)));
    add_directed(exec_beat(enc_branch(OP_CBNZ, 5'd1, 19'h3FFFF)));
    add_directed(exec_beat({CAT_HALT, 29'h1FFF_FFFF}));
    add_directed(exec_beat(32'hFFFF_FFFF));
    add_directed(exec_beat(32'h0000_0000));
    add_directed(exec_beat(enc_imm(7'd0, 5'd1, 5'd1, 12'd1)));
    add_directed(exec_beat(enc_reg(8'd161, 5'd1, 5'd1, 5'd1)));
    foreach (directed[i]) send_item(directed[i]);

    // Random phase, with a quiet stretch and a couple of full drains.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm <= (i >= 700 && i < 1000);
      if (i == 400 || i == 1300) wait_results_drained();
      send_item(make_random_item());
    end

    wait_results_drained();
    repeat (20) @(posedge clk);
    $display("Covered %0d input beats (%0d preloads) and checked %0d results",
             sb.issued, sb.preloads, sb.checked);
    $display("Seen %0d taken branches, %0d memory faults, %0d illegal words, %0d halts",
             sb.taken, sb.faults, sb.illegals, sb.halts);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop if the block hangs.
  initial begin
    #10_000_000;
    $display("Timeout with %0d results still expected", sb.pending());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
